>>> rtl/assert_macros.svh
// Assertion macros shared by the two-wire serial master RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, quiet while reset is asserted
`define TWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included
`define TWS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/tws_pkg.sv
// Types, command codes and microcode program of the two-wire serial master.
// Used by tws_seq, tws_dp and two_wire_serial_master_unit; no dependencies.
package tws_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
    localparam int WAIT_W        = 16;
    localparam int STEP_W        = 4;

    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd250;

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_SEND  = 2'd2;

    // Program entry points and loop target
    localparam logic [STEP_W-1:0] ADDR_START = 4'd0;
    localparam logic [STEP_W-1:0] ADDR_STOP  = 4'd4;
    localparam logic [STEP_W-1:0] ADDR_SEND  = 4'd8;
    localparam logic [STEP_W-1:0] ADDR_LOOP  = 4'd8;
    localparam logic [STEP_W-1:0] ADDR_LAST  = 4'd13;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       data_line_level;
    } in_item_t;

    typedef struct packed {
        logic clock_level;
        logic data_released;
        logic ack_good;
        logic last_phase;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        CLK_KEEP,
        CLK_LOW,
        CLK_HIGH
    } clk_op_t;

    typedef enum logic [1:0] {
        DAT_KEEP,
        DAT_LOW,
        DAT_HIGH,
        DAT_BIT
    } dat_op_t;

    // One microcode control word
    typedef struct packed {
        clk_op_t clk_op;
        dat_op_t dat_op;
        logic    shift;
        logic    ack;
        logic    last;
        logic    loop;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic   load;
        logic   fire;
        uword_t word;
    } ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic slot_free;
        logic bits_left;
    } dp_status_t;

    function automatic uword_t uw(clk_op_t c, dat_op_t d, logic s, logic a,
                                  logic l, logic j);
        uword_t w;
        w.clk_op = c;
        w.dat_op = d;
        w.shift  = s;
        w.ack    = a;
        w.last   = l;
        w.loop   = j;
        return w;
    endfunction

    // Microcode program: start, stop, then the send byte loop
    function automatic uword_t ucode(logic [STEP_W-1:0] addr);
        uword_t w;
        unique case (addr)
            4'd0:    w = uw(CLK_KEEP, DAT_HIGH, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd1:    w = uw(CLK_HIGH, DAT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd2:    w = uw(CLK_KEEP, DAT_LOW,  1'b0, 1'b0, 1'b0, 1'b0);
            4'd3:    w = uw(CLK_LOW,  DAT_KEEP, 1'b0, 1'b0, 1'b1, 1'b0);
            4'd4:    w = uw(CLK_LOW,  DAT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd5:    w = uw(CLK_KEEP, DAT_LOW,  1'b0, 1'b0, 1'b0, 1'b0);
            4'd6:    w = uw(CLK_HIGH, DAT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd7:    w = uw(CLK_KEEP, DAT_HIGH, 1'b0, 1'b0, 1'b1, 1'b0);
            4'd8:    w = uw(CLK_KEEP, DAT_BIT,  1'b0, 1'b0, 1'b0, 1'b0);
            4'd9:    w = uw(CLK_HIGH, DAT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd10:   w = uw(CLK_LOW,  DAT_KEEP, 1'b1, 1'b0, 1'b0, 1'b1);
            4'd11:   w = uw(CLK_KEEP, DAT_HIGH, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd12:   w = uw(CLK_HIGH, DAT_KEEP, 1'b0, 1'b0, 1'b0, 1'b0);
            4'd13:   w = uw(CLK_LOW,  DAT_KEEP, 1'b0, 1'b1, 1'b1, 1'b0);
            default: w = uw(CLK_KEEP, DAT_KEEP, 1'b0, 1'b0, 1'b1, 1'b0);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/two_wire_serial_master_unit.sv
// Top level of the two-wire serial master: APB register, sequencer, datapath.
// Depends on tws_pkg, tws_seq and tws_dp.

// A command beat (start, stop or send byte) turns into a series of line
// phase beats, 4 for start and stop and 27 for a send, each reporting the
// clock level and data state after the change; the last beat of a command
// has last_phase set, and on a send carries ack_good. Every phase waits out
// the phase wait counter, loaded from phase_wait_cycles (a value of zero
// counts as one), and waits further while the output is stalled; the next
// command beat can be taken in the cycle after the last phase fires.
// Command code 3 is taken and gives no beats. phase_wait_cycles is at APB
// byte address 0 and should only be written while no command is running.
module two_wire_serial_master_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  tws_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tws_pkg::out_item_t  out_data
);

    logic [tws_pkg::WAIT_W-1:0] phase_wait_reg;
    logic                       reg_hit;
    tws_pkg::ctl_t              ctl;
    tws_pkg::dp_status_t        status;

    // Register port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {{(32-tws_pkg::WAIT_W){1'b0}}, phase_wait_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_wait_reg <= tws_pkg::WAIT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            phase_wait_reg <= pwdata[tws_pkg::WAIT_W-1:0];
        end
    end

    tws_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (in_data.cmd),
        .phase_wait (phase_wait_reg),
        .status     (status),
        .ctl        (ctl)
    );

    tws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctl       (ctl),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> rtl/tws_seq.sv
// Microcode sequencer: step counter, phase wait counter and program ROM.
// Depends on tws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tws_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   cmd,
    input  logic [tws_pkg::WAIT_W-1:0]   phase_wait,
    input  tws_pkg::dp_status_t          status,
    output tws_pkg::ctl_t                ctl
);

    tws_pkg::state_t                  state_reg, state_next;
    logic [tws_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [tws_pkg::WAIT_W-1:0]       wait_reg, wait_next;
    logic [tws_pkg::WAIT_W-1:0]       wait_eff;
    logic                             accept;
    tws_pkg::uword_t                  word;

    // A zero wait value is taken as one
    assign wait_eff = (phase_wait == '0) ? {{(tws_pkg::WAIT_W-1){1'b0}}, 1'b1}
                                         : phase_wait;
    assign in_stall = (state_reg != tws_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign word     = tws_pkg::ucode(step_reg);

    // Hold state, step and wait counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tws_pkg::ST_IDLE;
            step_reg  <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
        end
    end

    // Advance through the program; fire a phase when the wait ends and
    // the output slot is free
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        ctl.load   = 1'b0;
        ctl.fire   = 1'b0;
        ctl.word   = word;
        unique case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                wait_next = '0;
                if (accept)
                begin
                    ctl.load  = (cmd == tws_pkg::CMD_SEND);
                    wait_next = wait_eff;
                    case (cmd)
                        tws_pkg::CMD_START:
                        begin
                            step_next  = tws_pkg::ADDR_START;
                            state_next = tws_pkg::ST_RUN;
                        end
                        tws_pkg::CMD_STOP:
                        begin
                            step_next  = tws_pkg::ADDR_STOP;
                            state_next = tws_pkg::ST_RUN;
                        end
                        tws_pkg::CMD_SEND:
                        begin
                            step_next  = tws_pkg::ADDR_SEND;
                            state_next = tws_pkg::ST_RUN;
                        end
                        default:
                        begin
                            wait_next = '0;
                        end
                    endcase
                end
            end
            tws_pkg::ST_RUN:
            begin
                if (wait_reg > {{(tws_pkg::WAIT_W-1){1'b0}}, 1'b1})
                begin
                    wait_next = wait_reg - 1'b1;
                end
                else if (status.slot_free)
                begin
                    ctl.fire = 1'b1;
                    if (word.last)
                    begin
                        state_next = tws_pkg::ST_IDLE;
                        wait_next  = '0;
                        step_next  = '0;
                    end
                    else
                    begin
                        wait_next = wait_eff;
                        if (word.loop && status.bits_left)
                        begin
                            step_next = tws_pkg::ADDR_LOOP;
                        end
                        else
                        begin
                            step_next = step_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = tws_pkg::ST_IDLE;
            end
        endcase
    end

    `TWS_ASSERT_ALWAYS(a_run_wait_nonzero, (state_reg == tws_pkg::ST_RUN) |-> (wait_reg != '0), "wait counter empty while running")
    `TWS_ASSERT(a_last_ends_run, (ctl.fire && word.last) |=> (state_reg == tws_pkg::ST_IDLE), "sequence did not end after last phase")
    `TWS_ASSERT(a_step_in_program, (state_reg == tws_pkg::ST_RUN) |-> (step_reg <= tws_pkg::ADDR_LAST), "step counter left the program")

endmodule

>>> rtl/tws_dp.sv
// Datapath: line levels, shift byte, bit counter and the result register.
// Depends on tws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tws_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tws_pkg::in_item_t    in_data,
    input  tws_pkg::ctl_t        ctl,
    output tws_pkg::dp_status_t  status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tws_pkg::out_item_t   out_data
);

    logic                              clk_line_reg, clk_line_next;
    logic                              dat_line_reg, dat_line_next;
    logic [tws_pkg::BITS_PER_BYTE-1:0] shift_reg, shift_next;
    logic [tws_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic                              ack_sample_reg, ack_sample_next;
    logic                              out_valid_reg, out_valid_next;
    tws_pkg::out_item_t                out_reg, out_next;

    assign status.slot_free = !out_valid_reg || !out_stall;
    assign status.bits_left = (bit_cnt_reg != '0);
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

    // Decode the control word into new line levels
    always_comb
    begin
        unique case (ctl.word.clk_op)
            tws_pkg::CLK_LOW:  clk_line_next = 1'b0;
            tws_pkg::CLK_HIGH: clk_line_next = 1'b1;
            default:           clk_line_next = clk_line_reg;
        endcase
        unique case (ctl.word.dat_op)
            tws_pkg::DAT_LOW:  dat_line_next = 1'b0;
            tws_pkg::DAT_HIGH: dat_line_next = 1'b1;
            tws_pkg::DAT_BIT:  dat_line_next = shift_reg[0];
            default:           dat_line_next = dat_line_reg;
        endcase
    end

    // Load the byte on a send, shift one bit per loop pass
    always_comb
    begin
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        ack_sample_next = ack_sample_reg;
        if (ctl.load)
        begin
            shift_next      = in_data.data_byte;
            bit_cnt_next    = tws_pkg::BIT_CNT_W'(tws_pkg::BITS_PER_BYTE - 1);
            ack_sample_next = in_data.data_line_level;
        end
        else if (ctl.fire && ctl.word.shift)
        begin
            shift_next   = shift_reg >> 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end
    end

    // Fill the result register on a phase, drop it when taken
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (ctl.fire)
        begin
            out_next.clock_level   = clk_line_next;
            out_next.data_released = dat_line_next;
            out_next.ack_good      = ctl.word.ack && !ack_sample_reg;
            out_next.last_phase    = ctl.word.last;
            out_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_line_reg   <= 1'b1;
            dat_line_reg   <= 1'b1;
            shift_reg      <= '0;
            bit_cnt_reg    <= '0;
            ack_sample_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.fire)
            begin
                clk_line_reg <= clk_line_next;
                dat_line_reg <= dat_line_next;
            end
            shift_reg      <= shift_next;
            bit_cnt_reg    <= bit_cnt_next;
            ack_sample_reg <= ack_sample_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `TWS_ASSERT(a_fire_sets_valid, ctl.fire |=> out_valid_reg, "phase result not presented")
    `TWS_ASSERT(a_no_overwrite, ctl.fire |-> (!out_valid_reg || !out_stall), "pending result overwritten")
    `TWS_ASSERT(a_ack_on_last, (out_valid_reg && out_reg.ack_good) |-> out_reg.last_phase, "acknowledge flagged before last phase")

endmodule
